// ----- hdl/gxb_pkg.sv -----
// Shared types and constants for the GF(2) XOR basis core.
package gxb_pkg;

   // Fixed widths of the item fields.
   localparam int VEC_W  = 64;
   localparam int RANK_W = 7;
   localparam int CNT_W  = 32;

   // Operation codes carried in the func field.
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   // Control that travels with a vector from one cell to the next.
   typedef struct packed {
      logic valid;  // an item occupies this stage
      logic func;   // operation code of the item
      logic done;   // the item has stopped at some pivot
      logic flag;   // result flag as known so far
   } ctl_type;

endpackage

// ----- hdl/gxb_cell.sv -----
// One pivot cell of the basis chain: holds the row for a single leading bit.
module gxb_cell
   import gxb_pkg::*;
#(
   parameter int WIDTH = 64,
   parameter int POS   = 63
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  ctl_type          up_ctl,
   input  logic [WIDTH-1:0] up_vec,
   output ctl_type          dn_ctl,
   output logic [WIDTH-1:0] dn_vec
);

   ctl_type          ctl_ff, ctl_in;
   logic [WIDTH-1:0] vec_ff, vec_in;
   logic [WIDTH-1:0] row_ff;
   logic             row_vld_ff;
   logic             row_write;
   logic             hit;

   // The item only acts here if it is still travelling and has this bit set.
   assign hit = up_ctl.valid && !up_ctl.done && up_vec[POS];

   always_comb begin
      ctl_in    = up_ctl;
      vec_in    = up_vec;
      row_write = 1'b0;
      if (hit) begin
         if (row_vld_ff) begin
            vec_in = up_vec ^ row_ff;
         end else begin
            ctl_in.done = 1'b1;
            if (up_ctl.func == FUNC_INSERT) begin
               row_write   = 1'b1;
               ctl_in.flag = 1'b1;
            end else begin
               ctl_in.flag = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff     <= '0;
         row_vld_ff <= 1'b0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
         if (row_write) begin
            row_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff <= vec_in;
         if (row_write) begin
            row_ff <= up_vec;
         end
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_vec = vec_ff;

endmodule

// ----- hdl/gxb_tally.sv -----
// Rank and insert counters at the end of the chain, plus the result register.
module gxb_tally
   import gxb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  ctl_type           end_ctl,
   output logic              out_valid,
   output logic              out_flag,
   output logic [RANK_W-1:0] out_rank,
   output logic [CNT_W-1:0]  out_dep
);

   logic [RANK_W-1:0] rank_ff, rank_in;
   logic [CNT_W-1:0]  ins_ff, ins_in;
   logic [CNT_W-1:0]  dep_in;
   logic              valid_ff;
   logic              flag_ff;
   logic [RANK_W-1:0] rank_out_ff;
   logic [CNT_W-1:0]  dep_ff;

   always_comb begin
      rank_in = rank_ff;
      ins_in  = ins_ff;
      if (end_ctl.valid && end_ctl.func == FUNC_INSERT) begin
         if (ins_ff != '1) begin
            ins_in = ins_ff + CNT_W'(1);
         end
         if (end_ctl.flag) begin
            rank_in = rank_ff + RANK_W'(1);
         end
      end
      if (ins_in > CNT_W'(rank_in)) begin
         dep_in = ins_in - CNT_W'(rank_in);
      end else begin
         dep_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff  <= '0;
         ins_ff   <= '0;
         valid_ff <= 1'b0;
      end else if (advance) begin
         rank_ff  <= rank_in;
         ins_ff   <= ins_in;
         valid_ff <= end_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && end_ctl.valid) begin
         flag_ff     <= end_ctl.flag;
         rank_out_ff <= rank_in;
         dep_ff      <= dep_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_flag  = flag_ff;
   assign out_rank  = rank_out_ff;
   assign out_dep   = dep_ff;

endmodule

// ----- hdl/gf2_xor_basis_core.sv -----
// Top level of the GF(2) XOR basis core: a chain of pivot cells and a result tally.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall req_func, req_vector
//   rsp      out        rsp_valid/rsp_stall rsp_flag, rsp_rank, rsp_dependent_count
//
// One item may enter in every cycle unless a stalled result holds the chain; the
// chain of WIDTH pivot cells moves all items forward together, so the sustained
// rate is one item per cycle while rsp_stall is not raised against a valid result.
// An accepted item passes through the WIDTH pivot cell registers in order and then
// the result register, where its result appears.
// Reset clears every row valid bit, the rank and the insert count at once, so the
// block takes items in the first cycle after reset.
// A stalled result freezes the whole chain, and req_stall is raised in that cycle.
module gf2_xor_basis_core
   import gxb_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [VEC_W-1:0]  req_vector,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_flag,
   output logic [RANK_W-1:0] rsp_rank,
   output logic [CNT_W-1:0]  rsp_dependent_count
);

   // The chain advances whenever the result register is free or being drained.
   logic advance;

   // Stage k feeds the cell whose pivot is bit WIDTH-1-k; stage WIDTH is the end.
   ctl_type          ctl_chain [WIDTH+1];
   logic [WIDTH-1:0] vec_chain [WIDTH+1];

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // A query starts out claiming membership; it is cleared if the vector hits a
   // missing pivot. An insert starts out dependent and is set when it is stored.
   // Bits at and above WIDTH simply never enter the chain.
   always_comb begin
      ctl_chain[0].valid = req_valid;
      ctl_chain[0].func  = req_func;
      ctl_chain[0].done  = 1'b0;
      ctl_chain[0].flag  = (req_func == FUNC_QUERY);
      vec_chain[0]       = req_vector[WIDTH-1:0];
   end

   // Each cell sees the row it may have just written before the next item
   // reaches it, because items move exactly one cell per advance.
   for (genvar k = 0; k < WIDTH; k++) begin : g_cell
      gxb_cell #(
         .WIDTH (WIDTH),
         .POS   (WIDTH - 1 - k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_ctl  (ctl_chain[k]),
         .up_vec  (vec_chain[k]),
         .dn_ctl  (ctl_chain[k+1]),
         .dn_vec  (vec_chain[k+1])
      );
   end

   // An item that leaves the chain without stopping has been reduced to zero, so
   // its starting flag is already the right answer for both operations.
   gxb_tally u_tally (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .end_ctl   (ctl_chain[WIDTH]),
      .out_valid (rsp_valid),
      .out_flag  (rsp_flag),
      .out_rank  (rsp_rank),
      .out_dep   (rsp_dependent_count)
   );

   // The rank reported can never exceed the number of pivot cells.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rank <= RANK_W'(WIDTH)))
      else $error("rank exceeds the number of pivots");

   // Back-to-back results differ in rank by at most one stored row.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && !$past(reset)) |->
         ((rsp_rank == $past(rsp_rank)) || (rsp_rank == $past(rsp_rank) + RANK_W'(1))))
      else $error("rank moved by more than one between results");

   // An accepted item must occupy the first cell in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> ctl_chain[1].valid)
      else $error("accepted item lost at the head of the chain");

endmodule
